>>> hdl/dfa_word_matcher_macros.svh
// Assertion macros for the DFA word matcher.
`ifndef DFA_WORD_MATCHER_MACROS_SVH
`define DFA_WORD_MATCHER_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define DWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define DWM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hdl/dwm_pkg.sv
// Types and constants shared by the DFA word matcher modules.
`timescale 1ns / 1ps
package dwm_pkg;

  localparam int unsigned NumStates  = 4096;
  localparam int unsigned NumLetters = 26;
  localparam int unsigned StateW     = 12;
  localparam int unsigned LetterW    = 5;
  localparam int unsigned FifoDepth  = 2;

  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChUpperZ = 8'h5A;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChLowerZ = 8'h7A;

  localparam logic RegStart = 1'b0;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_MARK = 2'd1,
    OP_CHAR = 2'd2,
    OP_EOW  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_MARK,
    CMD_CHAR,
    CMD_SEP,
    CMD_EOW
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [StateW-1:0]  source_state;
    logic [LetterW-1:0] letter;
    logic [StateW-1:0]  target_state;
    logic [7:0]         char_byte;
  } in_t;

  typedef struct packed {
    logic              blocked;
    logic [StateW-1:0] end_state;
  } out_t;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [StateW-1:0]  state;
    logic [LetterW-1:0] letter;
    logic [StateW-1:0]  target;
  } cmd_t;

  typedef struct packed {
    logic              valid;
    logic [StateW-1:0] target;
  } entry_t;

  typedef entry_t [NumLetters-1:0] row_t;

  typedef struct packed {
    logic clearing;
    logic reloading;
  } stat_t;

endpackage

>>> hdl/dwm_front.sv
// Input stage: accepts beats and classifies them into commands.
`timescale 1ns / 1ps
module dwm_front (
  input  logic           in_valid_i,
  input  dwm_pkg::in_t   in_i,
  output logic           in_ready_o,
  input  dwm_pkg::stat_t stat_i,
  input  logic           cmd_ready_i,
  output logic           cmd_valid_o,
  output dwm_pkg::cmd_t  cmd_o
);

  logic is_upper;
  logic is_lower;

  assign is_upper = (in_i.char_byte >= dwm_pkg::ChUpperA) &&
                    (in_i.char_byte <= dwm_pkg::ChUpperZ);
  assign is_lower = (in_i.char_byte >= dwm_pkg::ChLowerA) &&
                    (in_i.char_byte <= dwm_pkg::ChLowerZ);

  assign in_ready_o  = cmd_ready_i && !stat_i.clearing && !stat_i.reloading;
  assign cmd_valid_o = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.state  = in_i.source_state;
    cmd_o.letter = in_i.letter;
    cmd_o.target = in_i.target_state;
    case (dwm_pkg::op_e'(in_i.op))
      dwm_pkg::OP_LOAD: begin
        cmd_o.kind = (in_i.letter < dwm_pkg::LetterW'(dwm_pkg::NumLetters)) ?
                     dwm_pkg::CMD_LOAD : dwm_pkg::CMD_NOP;
      end
      dwm_pkg::OP_MARK: begin
        cmd_o.kind = dwm_pkg::CMD_MARK;
      end
      dwm_pkg::OP_CHAR: begin
        // fold case: both ranges map low five bits 1..26 to letter 0..25
        cmd_o.letter = in_i.char_byte[dwm_pkg::LetterW-1:0] - dwm_pkg::LetterW'(1);
        cmd_o.kind   = (is_upper || is_lower) ? dwm_pkg::CMD_CHAR : dwm_pkg::CMD_SEP;
      end
      dwm_pkg::OP_EOW: begin
        cmd_o.kind = dwm_pkg::CMD_EOW;
      end
      default: begin
        cmd_o.kind = dwm_pkg::CMD_NOP;
      end
    endcase
  end

endmodule

>>> hdl/dwm_fifo.sv
// Short command queue between the input stage and the scan engine.
`timescale 1ns / 1ps
module dwm_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dwm_pkg::cmd_t data_i,
  output logic          ready_o,
  output logic          valid_o,
  output dwm_pkg::cmd_t data_o,
  input  logic          pop_i
);

  localparam int unsigned PtrW = $clog2(dwm_pkg::FifoDepth);
  localparam int unsigned CntW = $clog2(dwm_pkg::FifoDepth + 1);

  dwm_pkg::cmd_t   mem_q [dwm_pkg::FifoDepth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] cnt_d;
  logic            do_pop;

  assign ready_o = (cnt_q != CntW'(dwm_pkg::FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, do_pop})
      2'b10: begin
        cnt_d = cnt_q + CntW'(1);
      end
      2'b01: begin
        cnt_d = cnt_q - CntW'(1);
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(dwm_pkg::FifoDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(dwm_pkg::FifoDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

endmodule

>>> hdl/dwm_exec.sv
// Scan engine: transition and final-flag memories, current state, result register.
`timescale 1ns / 1ps
`include "dfa_word_matcher_macros.svh"
module dwm_exec (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  dwm_pkg::cmd_t              cmd_i,
  output logic                       cmd_ready_o,
  input  logic                       cfg_we_i,
  input  logic [dwm_pkg::StateW-1:0] cfg_start_i,
  input  logic [dwm_pkg::StateW-1:0] start_i,
  output dwm_pkg::stat_t             stat_o,
  output logic                       out_valid_o,
  output dwm_pkg::out_t              out_o,
  input  logic                       out_ready_i
);

  dwm_pkg::row_t              row_mem [dwm_pkg::NumStates];
  logic                       fin_mem [dwm_pkg::NumStates];

  dwm_pkg::row_t              row_q;
  logic                       fr_q;
  logic [dwm_pkg::StateW-1:0] cur_q, cur_d;
  logic                       stop_q, stop_d;
  logic                       arr_q, arr_d;
  logic                       mk_q, mk_d;
  logic                       clr_q;
  logic [dwm_pkg::StateW-1:0] cnt_q;
  logic                       load_q;
  logic                       out_valid_q;
  dwm_pkg::out_t              out_q;

  logic                       out_free;
  logic                       pop;
  logic                       stopped;
  logic                       rd_en;
  logic                       patch;
  dwm_pkg::entry_t            entry;
  dwm_pkg::entry_t            new_entry;

  assign out_free    = !out_valid_q || out_ready_i;
  assign cmd_ready_o = !clr_q && !load_q &&
                       ((cmd_i.kind != dwm_pkg::CMD_EOW) || out_free);
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign stopped     = stop_q || (arr_q && fr_q);
  assign entry       = row_q[cmd_i.letter];
  assign new_entry   = '{valid: 1'b1, target: cmd_i.target};

  assign stat_o      = '{clearing: clr_q, reloading: load_q};
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    cur_d  = cur_q;
    stop_d = stop_q;
    arr_d  = arr_q;
    mk_d   = mk_q;
    rd_en  = load_q;
    patch  = 1'b0;
    if (cfg_we_i) begin
      cur_d  = cfg_start_i;
      stop_d = 1'b0;
      arr_d  = 1'b0;
      rd_en  = 1'b1;
    end else if (pop) begin
      case (cmd_i.kind)
        dwm_pkg::CMD_LOAD: begin
          patch = (cmd_i.state == cur_q);
        end
        dwm_pkg::CMD_MARK: begin
          if (cmd_i.state == cur_q) begin
            mk_d = 1'b1;
          end
        end
        dwm_pkg::CMD_SEP: begin
          if (!stopped) begin
            cur_d = '0;
            arr_d = 1'b0;
            rd_en = 1'b1;
          end
        end
        dwm_pkg::CMD_CHAR: begin
          if (!stopped) begin
            if (entry.valid) begin
              cur_d = entry.target;
              arr_d = 1'b1;
              rd_en = 1'b1;
            end else begin
              stop_d = 1'b1;
            end
          end
        end
        dwm_pkg::CMD_EOW: begin
          cur_d  = start_i;
          stop_d = 1'b0;
          arr_d  = 1'b0;
          rd_en  = 1'b1;
        end
        default: begin
          cur_d = cur_q;
        end
      endcase
    end
    if (rd_en) begin
      mk_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      row_mem[cnt_q] <= '0;
      fin_mem[cnt_q] <= 1'b0;
    end else if (pop && (cmd_i.kind == dwm_pkg::CMD_LOAD)) begin
      row_mem[cmd_i.state][cmd_i.letter] <= new_entry;
    end else if (pop && (cmd_i.kind == dwm_pkg::CMD_MARK)) begin
      fin_mem[cmd_i.state] <= 1'b1;
    end
    if (rd_en) begin
      row_q <= row_mem[cur_d];
      fr_q  <= fin_mem[cur_d];
    end else if (patch) begin
      row_q[cmd_i.letter] <= new_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && (cmd_i.kind == dwm_pkg::CMD_EOW)) begin
      out_q <= '{blocked: fr_q || mk_q, end_state: cur_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= 1'b1;
      cnt_q       <= '0;
      load_q      <= 1'b0;
      cur_q       <= '0;
      stop_q      <= 1'b0;
      arr_q       <= 1'b0;
      mk_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_q  <= cur_d;
      stop_q <= stop_d;
      arr_q  <= arr_d;
      mk_q   <= mk_d;
      load_q <= clr_q && (cnt_q == dwm_pkg::StateW'(dwm_pkg::NumStates - 1));
      if (clr_q) begin
        cnt_q <= cnt_q + dwm_pkg::StateW'(1);
        if (cnt_q == dwm_pkg::StateW'(dwm_pkg::NumStates - 1)) begin
          clr_q <= 1'b0;
        end
      end
      if (pop && (cmd_i.kind == dwm_pkg::CMD_EOW)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `DWM_ASSERT_ALWAYS(a_no_pop_in_clear, !(clr_q && cmd_valid_i && cmd_ready_o), "pop during clear")
  `DWM_ASSERT(a_reload_after_clear, $fell(clr_q) |-> load_q, "no reload after clear")
  `DWM_ASSERT(a_patch_xor_read, !(rd_en && patch), "row patch and row read collide")
  `DWM_ASSERT(a_eow_result, (pop && (cmd_i.kind == dwm_pkg::CMD_EOW)) |=> (out_valid_q && (out_q.end_state == $past(cur_q))), "end-of-word result lost")

endmodule

>>> hdl/dfa_word_matcher.sv
// Top level of the DFA word matcher: config register, input stage, queue, scan engine.
// Throughput: one beat per cycle on the input when the queue has room, back-to-back characters too.
// An end-of-word beat passes the queue, then the result register, before its result is shown.
// The next-state row of the current state is held in a register; each character picks a lane,
// and that target addresses the row memory read for the following character.
// Reset: clears all 4096 states, then reloads the current row, with in_ready_o low throughout.
`timescale 1ns / 1ps
module dfa_word_matcher (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  dwm_pkg::in_t in_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  output dwm_pkg::out_t out_o,
  input  logic         out_ready_i,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [dwm_pkg::StateW-1:0] start_q;
  logic                       cfg_we;
  logic                       front_valid;
  dwm_pkg::cmd_t              front_cmd;
  logic                       fifo_ready;
  logic                       fifo_valid;
  dwm_pkg::cmd_t              fifo_cmd;
  logic                       exec_ready;
  dwm_pkg::stat_t             stat;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == dwm_pkg::RegStart);
  assign prdata = (paddr[2] == dwm_pkg::RegStart) ?
                  {{(32 - dwm_pkg::StateW){1'b0}}, start_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
    end else if (cfg_we) begin
      start_q <= pwdata[dwm_pkg::StateW-1:0];
    end
  end

  dwm_front u_front (
    .in_valid_i  (in_valid_i),
    .in_i        (in_i),
    .in_ready_o  (in_ready_o),
    .stat_i      (stat),
    .cmd_ready_i (fifo_ready),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd)
  );

  dwm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_cmd),
    .ready_o (fifo_ready),
    .valid_o (fifo_valid),
    .data_o  (fifo_cmd),
    .pop_i   (exec_ready)
  );

  dwm_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (fifo_valid),
    .cmd_i       (fifo_cmd),
    .cmd_ready_o (exec_ready),
    .cfg_we_i    (cfg_we),
    .cfg_start_i (pwdata[dwm_pkg::StateW-1:0]),
    .start_i     (start_q),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .out_ready_i (out_ready_i)
  );

endmodule

>>> tb/dfa_word_matcher_checker.sv
// Scoreboard for the DFA word matcher: mirrors the tables and scores every result beat.
`timescale 1ns / 1ps
module dfa_word_matcher_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  dwm_pkg::in_t  in_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  dwm_pkg::out_t out_i,
  input  logic          psel_i,
  input  logic          penable_i,
  input  logic          pwrite_i,
  input  logic          pready_i,
  input  logic [2:0]    paddr_i,
  input  logic [31:0]   pwdata_i,
  output int unsigned   fail_cnt_o,
  output int unsigned   open_cnt_o,
  output int unsigned   scored_cnt_o,
  output int unsigned   blocked_cnt_o
);

  bit                         link_ok   [dwm_pkg::NumStates][dwm_pkg::NumLetters];
  logic [dwm_pkg::StateW-1:0] link_to   [dwm_pkg::NumStates][dwm_pkg::NumLetters];
  bit                         accepting [dwm_pkg::NumStates];
  logic [dwm_pkg::StateW-1:0] word_start;
  logic [dwm_pkg::StateW-1:0] scan_state;
  bit                         scan_halted;
  dwm_pkg::out_t              verdict_q [$];
  int unsigned                fails;
  int unsigned                scored;
  int unsigned                blocked_words;

  function automatic void scan_char(input logic [7:0] ch);
    logic [7:0]  folded;
    int unsigned idx;
    if (scan_halted) return;
    folded = ch;
    if (ch >= dwm_pkg::ChUpperA && ch <= dwm_pkg::ChUpperZ) begin
      folded = ch - dwm_pkg::ChUpperA + dwm_pkg::ChLowerA;
    end
    if (folded < dwm_pkg::ChLowerA || folded > dwm_pkg::ChLowerZ) begin
      scan_state = '0;
      return;
    end
    idx = 32'(folded - dwm_pkg::ChLowerA);
    if (idx >= dwm_pkg::NumLetters || !link_ok[scan_state][idx]) begin
      scan_halted = 1'b1;
      return;
    end
    scan_state = link_to[scan_state][idx];
    if (accepting[scan_state]) scan_halted = 1'b1;
  endfunction

  function automatic void flag(input string what);
    fails++;
    if (fails <= 10) $display("[%0t] result mismatch: %s", $time, what);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dwm_pkg::out_t want;
    if (!rst_ni) begin
      foreach (link_ok[s, l]) link_ok[s][l] = 1'b0;
      foreach (accepting[s]) accepting[s] = 1'b0;
      word_start    = '0;
      scan_state    = '0;
      scan_halted   = 1'b0;
      verdict_q.delete();
      fails         = 0;
      scored        = 0;
      blocked_words = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && (paddr_i >> 2) == dwm_pkg::RegStart) begin
        word_start  = pwdata_i[dwm_pkg::StateW-1:0];
        scan_state  = word_start;
        scan_halted = 1'b0;
      end
      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          flag($sformatf("unexpected beat blocked=%0b end_state=%0d",
                         out_i.blocked, out_i.end_state));
        end else begin
          want = verdict_q.pop_front();
          scored++;
          if (want.blocked) blocked_words++;
          if (out_i.blocked !== want.blocked || out_i.end_state !== want.end_state) begin
            flag($sformatf("expected blocked=%0b end_state=%0d, got blocked=%0b end_state=%0d",
                           want.blocked, want.end_state, out_i.blocked, out_i.end_state));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (in_i.op)
          dwm_pkg::OP_LOAD: begin
            if (in_i.letter < dwm_pkg::NumLetters) begin
              link_ok[in_i.source_state][in_i.letter] = 1'b1;
              link_to[in_i.source_state][in_i.letter] = in_i.target_state;
            end
          end
          dwm_pkg::OP_MARK: accepting[in_i.source_state] = 1'b1;
          dwm_pkg::OP_CHAR: scan_char(in_i.char_byte);
          default: begin
            want.blocked   = accepting[scan_state];
            want.end_state = scan_state;
            verdict_q      = {verdict_q, want};
            scan_state     = word_start;
            scan_halted    = 1'b0;
          end
        endcase
      end
    end
    fail_cnt_o    <= fails;
    open_cnt_o    <= verdict_q.size();
    scored_cnt_o  <= scored;
    blocked_cnt_o <= blocked_words;
  end

endmodule

>>> tb/tb_dfa_word_matcher.sv
// Testbench top for the DFA word matcher: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_dfa_word_matcher;

  localparam int unsigned StallLimit  = 20000;
  localparam int unsigned HoldOff     = 400;
  localparam int unsigned PhaseBeats  = 610;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned PoolSize    = 6;
  localparam int unsigned AbcSize     = 4;
  localparam logic [2:0]  AddrStart   = {dwm_pkg::RegStart, 2'b00};
  localparam logic [2:0]  AddrSpare   = {~dwm_pkg::RegStart, 2'b00};

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  dwm_pkg::in_t  in_i;
  logic          in_ready_o;
  logic          out_valid_o;
  dwm_pkg::out_t out_o;
  logic          out_ready_i;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [2:0]    paddr;
  logic [31:0]   pwdata;
  logic [31:0]   prdata;
  logic          pready;

  int unsigned                 send_idle    = 15;
  int unsigned                 recv_idle    = 53;
  bit                          hold_req     = 1'b0;
  int unsigned                 beats_sent   = 0;
  int unsigned                 settings_cnt = 0;
  int unsigned                 quiet        = 0;
  logic [dwm_pkg::StateW-1:0]  cur_start    = '0;
  logic [dwm_pkg::StateW-1:0]  pool     [PoolSize];
  logic [dwm_pkg::LetterW-1:0] alphabet [AbcSize];
  int unsigned                 fail_cnt;
  int unsigned                 open_cnt;
  int unsigned                 scored_cnt;
  int unsigned                 blocked_cnt;

  dfa_word_matcher DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_i        (in_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .out_ready_i (out_ready_i),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  dfa_word_matcher_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_i          (in_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_i         (out_o),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .fail_cnt_o    (fail_cnt),
    .open_cnt_o    (open_cnt),
    .scored_cnt_o  (scored_cnt),
    .blocked_cnt_o (blocked_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    int unsigned hold_left;
    bit          hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HoldOff;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet <= 0;
    end else if (quiet == StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic dwm_pkg::in_t noise_beat();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return dwm_pkg::in_t'(r[$bits(dwm_pkg::in_t)-1:0]);
  endfunction

  function automatic dwm_pkg::in_t make_beat(input dwm_pkg::op_e op,
                                             input logic [dwm_pkg::StateW-1:0] src,
                                             input logic [dwm_pkg::LetterW-1:0] ltr,
                                             input logic [dwm_pkg::StateW-1:0] tgt,
                                             input logic [7:0] ch);
    dwm_pkg::in_t b;
    b    = noise_beat();
    b.op = op;
    case (op)
      dwm_pkg::OP_LOAD: begin
        b.source_state = src;
        b.letter       = ltr;
        b.target_state = tgt;
      end
      dwm_pkg::OP_MARK: b.source_state = src;
      dwm_pkg::OP_CHAR: b.char_byte = ch;
      default: ;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] pick_char();
    int unsigned r;
    logic [7:0]  ltr;
    r = $urandom_range(99);
    if (r < 80) ltr = 8'(alphabet[$urandom_range(AbcSize-1)]);
    else ltr = 8'($urandom_range(dwm_pkg::NumLetters-1));
    if (r < 88) begin
      return $urandom_range(1) ? dwm_pkg::ChUpperA + ltr : dwm_pkg::ChLowerA + ltr;
    end
    if (r < 94) return 8'($urandom_range(255));
    case ($urandom_range(3))
      0:       return dwm_pkg::ChUpperA - 8'd1;
      1:       return dwm_pkg::ChUpperZ + 8'd1;
      2:       return dwm_pkg::ChLowerA - 8'd1;
      default: return dwm_pkg::ChLowerZ + 8'd1;
    endcase
  endfunction

  task automatic push_beat(input dwm_pkg::in_t b);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic send_load(input logic [dwm_pkg::StateW-1:0] src,
                           input logic [dwm_pkg::LetterW-1:0] ltr,
                           input logic [dwm_pkg::StateW-1:0] tgt);
    push_beat(make_beat(dwm_pkg::OP_LOAD, src, ltr, tgt, '0));
  endtask

  task automatic send_mark(input logic [dwm_pkg::StateW-1:0] src);
    push_beat(make_beat(dwm_pkg::OP_MARK, src, '0, '0, '0));
  endtask

  task automatic send_char(input logic [7:0] ch);
    push_beat(make_beat(dwm_pkg::OP_CHAR, '0, '0, '0, ch));
  endtask

  task automatic send_eow();
    push_beat(make_beat(dwm_pkg::OP_EOW, '0, '0, '0, '0));
  endtask

  task automatic wait_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (open_cnt != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_start(input logic [dwm_pkg::StateW-1:0] start);
    logic [31:0] w;
    w = $urandom();
    w[dwm_pkg::StateW-1:0] = start;
    write_reg(AddrStart, w);
    cur_start = start;
    settings_cnt++;
  endtask

  task automatic dfa_round();
    int unsigned n_chars;
    int unsigned r;
    pool[0] = cur_start;
    pool[1] = '0;
    for (int i = 2; i < PoolSize; i++) begin
      pool[i] = dwm_pkg::StateW'($urandom_range(dwm_pkg::NumStates-1));
      if ($urandom_range(9) == 0) pool[i] = '1;
    end
    foreach (alphabet[j]) alphabet[j] = dwm_pkg::LetterW'($urandom_range(dwm_pkg::NumLetters-1));
    foreach (pool[i]) begin
      foreach (alphabet[j]) begin
        if ($urandom_range(9) < 7) send_load(pool[i], alphabet[j], pool[$urandom_range(PoolSize-1)]);
      end
    end
    if ($urandom_range(3) == 0) begin
      send_load(pool[$urandom_range(PoolSize-1)],
                dwm_pkg::LetterW'($urandom_range(31, dwm_pkg::NumLetters)),
                dwm_pkg::StateW'($urandom_range(dwm_pkg::NumStates-1)));
    end
    if ($urandom_range(1) == 0) send_mark(pool[$urandom_range(PoolSize-1, 2)]);
    repeat ($urandom_range(10, 4)) begin
      n_chars = ($urandom_range(9) == 0) ? 0 : $urandom_range(8, 1);
      repeat (n_chars) begin
        r = $urandom_range(99);
        if (r < 3) begin
          send_load(pool[$urandom_range(PoolSize-1)], alphabet[$urandom_range(AbcSize-1)],
                    pool[$urandom_range(PoolSize-1)]);
        end else if (r < 5) begin
          push_beat(noise_beat());
        end else begin
          send_char(pick_char());
        end
      end
      send_eow();
    end
  endtask

  task automatic run_phase(input int unsigned s_idle, input int unsigned r_idle,
                           input logic [dwm_pkg::StateW-1:0] start, input bit pressure);
    int unsigned stop_at;
    int unsigned round_no;
    // leave a word open across the register write
    send_char(pick_char());
    send_char(pick_char());
    wait_results();
    set_start(start);
    send_idle = s_idle;
    recv_idle = r_idle;
    stop_at   = beats_sent + PhaseBeats;
    round_no  = 0;
    while (beats_sent < stop_at) begin
      if (pressure && round_no == 1) hold_req = ~hold_req;
      if (round_no == 2 || $urandom_range(9) == 0) wait_results();
      dfa_round();
      round_no++;
    end
  endtask

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_i       <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    foreach (alphabet[j]) alphabet[j] = dwm_pkg::LetterW'(j);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);

    send_eow();
    send_load('0, 5'd0, '1);
    send_load('1, 5'd25, 12'd7);
    send_load('1, 5'd31, 12'd1);
    send_load('1, 5'(dwm_pkg::NumLetters), 12'd1);
    send_mark(12'd7);
    send_char(dwm_pkg::ChUpperA);
    send_load('1, 5'd25, 12'd9);
    send_char(dwm_pkg::ChLowerZ);
    send_eow();
    send_char(dwm_pkg::ChLowerA);
    send_char(8'hFF);
    send_char(dwm_pkg::ChLowerA);
    send_char(dwm_pkg::ChLowerA + 8'd1);
    send_char(dwm_pkg::ChLowerA);
    send_eow();
    send_load('1, 5'd25, 12'd7);
    send_char(dwm_pkg::ChLowerA);
    send_char(dwm_pkg::ChUpperZ);
    send_char(dwm_pkg::ChUpperA - 8'd1);
    send_eow();
    send_mark('1);
    send_char(dwm_pkg::ChLowerA);
    wait_results();
    write_reg(AddrSpare, $urandom());
    send_eow();
    wait_results();
    set_start('1);
    send_eow();
    send_char(dwm_pkg::ChLowerZ);
    send_eow();

    run_phase(15, 53, dwm_pkg::StateW'($urandom_range(dwm_pkg::NumStates-1)), 1'b0);
    run_phase(53, 15, '1, 1'b0);
    run_phase(0, 0, '0, 1'b1);
    wait_results();

    $display("Scored %0d words (%0d blocked) from %0d input beats.",
             scored_cnt, blocked_cnt, beats_sent);
    $display("Swept %0d start-state settings, three idling mixes and a full-queue stall.",
             settings_cnt);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
